>>> rtl/core/pngu_pkg.sv
// PNG scanline unfilter: shared types, register indexes and the Paeth predictor.
// No dependencies; imported by pngu_ctrl, pngu_recon, the top level and the testbench.
`timescale 1ns / 1ps

package pngu_pkg;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filter_t;

  localparam logic [7:0] FILT_MAX_CODE = 8'd4;

  // configuration register indexes
  localparam logic CFG_LINE_BYTES      = 1'b0;
  localparam logic CFG_BYTES_PER_PIXEL = 1'b1;

  localparam int LINE_CFG_W = 13;
  localparam int BPP_CFG_W  = 4;

  // one item handed from the control stage to reconstruction
  typedef struct packed {
    logic [7:0] data;
    filter_t    filt;
    logic       first;   // first data byte of the row: left history reads zero
    logic       top;     // first row of the image: upper byte reads zero
    logic       last;
    logic       bad;     // error beat, no reconstruction
  } item_t;

  function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
    logic signed [10:0] da;
    logic signed [10:0] db;
    logic signed [10:0] dc;
    logic [9:0] pa;
    logic [9:0] pb;
    logic [9:0] pc;
    da = $signed({3'b000, b}) - $signed({3'b000, c});
    db = $signed({3'b000, a}) - $signed({3'b000, c});
    dc = $signed({3'b000, a}) + $signed({3'b000, b}) - $signed({2'b00, c, 1'b0});
    pa = da[10] ? 10'(-da) : da[9:0];
    pb = db[10] ? 10'(-db) : db[9:0];
    pc = dc[10] ? 10'(-dc) : dc[9:0];
    if (pa <= pb && pa <= pc) return a;
    else if (pb <= pc) return b;
    else return c;
  endfunction

endpackage

>>> rtl/core/pngu_row_mem.sv
// Previous-row store: single write port, one registered read port.
// Depends on nothing; instantiated by png_scanline_unfilter.
`timescale 1ns / 1ps

module pngu_row_mem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data
);

  logic [7:0] mem_r [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // data holds until the next read, so a stalled beat keeps its upper byte
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/core/pngu_ctrl.sv
// Input stage: configuration registers, row/column tracking, filter-byte decode.
// Depends on pngu_pkg; issues row-memory reads and items for pngu_recon.
`timescale 1ns / 1ps

module pngu_ctrl #(
  parameter int MAX_LINE_BYTES  = 4096,
  parameter int MAX_PIXEL_BYTES = 8,
  parameter int CW = 13,
  parameter int AW = 12,
  parameter int KW = 3
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [pngu_pkg::LINE_CFG_W-1:0]    cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [7:0]                         in_stream_byte,
  input  logic                               in_new_image,
  input  logic                               s1_free,
  output logic                               push,
  output pngu_pkg::item_t                    push_item,
  output logic                               rd_en,
  output logic [AW-1:0]                      rd_idx,
  output logic [KW-1:0]                      left_sel
);

  import pngu_pkg::*;

  logic [LINE_CFG_W-1:0] line_bytes_r;
  logic [BPP_CFG_W-1:0]  bpp_r;
  logic [CW-1:0]         column_r, column_nxt;
  filter_t               row_filter_r, row_filter_nxt;
  logic                  top_row_r, top_row_nxt;
  logic                  halted_r, halted_nxt;

  logic [LINE_CFG_W-1:0] line_min1;
  logic [CW-1:0]         eff_line;
  logic [BPP_CFG_W-1:0]  bpp_min1;
  logic [BPP_CFG_W-1:0]  eff_bpp;
  logic                  accept;
  logic [CW-1:0]         col_eff;
  logic                  top_eff;
  logic                  halt_eff;
  logic                  last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_bytes_r <= LINE_CFG_W'(1);
      bpp_r        <= BPP_CFG_W'(1);
    end else if (cfg_we) begin
      if (cfg_index == CFG_LINE_BYTES) begin
        line_bytes_r <= cfg_wdata;
      end else begin
        bpp_r <= cfg_wdata[BPP_CFG_W-1:0];
      end
    end
  end

  assign line_min1 = (line_bytes_r == '0) ? LINE_CFG_W'(1) : line_bytes_r;
  assign eff_line  = (32'(line_min1) > 32'(MAX_LINE_BYTES)) ? CW'(MAX_LINE_BYTES)
                                                            : CW'(line_min1);
  assign bpp_min1  = (bpp_r == '0) ? BPP_CFG_W'(1) : bpp_r;
  assign eff_bpp   = (32'(bpp_min1) > 32'(MAX_PIXEL_BYTES)) ? BPP_CFG_W'(MAX_PIXEL_BYTES)
                                                           : bpp_min1;
  assign left_sel  = KW'(eff_bpp - BPP_CFG_W'(1));

  assign in_ready = s1_free;
  assign accept   = in_valid && in_ready;

  // a new-image beat always restarts at a filter byte
  assign col_eff  = in_new_image ? '0 : column_r;
  assign top_eff  = in_new_image ? 1'b1 : top_row_r;
  assign halt_eff = in_new_image ? 1'b0 : halted_r;
  assign last     = (col_eff >= eff_line);
  assign rd_idx   = AW'(col_eff - CW'(1));

  always_comb begin
    column_nxt     = column_r;
    row_filter_nxt = row_filter_r;
    top_row_nxt    = top_row_r;
    halted_nxt     = halted_r;
    push           = 1'b0;
    rd_en          = 1'b0;
    push_item      = '{data: in_stream_byte, filt: row_filter_r,
                       first: (col_eff == CW'(1)), top: top_eff,
                       last: last, bad: 1'b0};
    if (accept) begin
      column_nxt  = col_eff;
      top_row_nxt = top_eff;
      halted_nxt  = halt_eff;
      priority if (halt_eff) begin
        // dropped until the next image
      end else if (col_eff == '0) begin
        if (in_stream_byte > FILT_MAX_CODE) begin
          halted_nxt     = 1'b1;
          push           = 1'b1;
          push_item.bad  = 1'b1;
          push_item.last = 1'b0;
        end else begin
          row_filter_nxt = filter_t'(in_stream_byte[2:0]);
          column_nxt     = CW'(1);
        end
      end else begin
        push  = 1'b1;
        rd_en = 1'b1;
        if (last) begin
          column_nxt  = '0;
          top_row_nxt = 1'b0;
        end else begin
          column_nxt = col_eff + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r     <= '0;
      row_filter_r <= FILT_NONE;
      top_row_r    <= 1'b1;
      halted_r     <= 1'b0;
    end else begin
      column_r     <= column_nxt;
      row_filter_r <= row_filter_nxt;
      top_row_r    <= top_row_nxt;
      halted_r     <= halted_nxt;
    end
  end

endmodule

>>> rtl/core/pngu_recon.sv
// Reconstruction stage: predictor, left/upper-left history, row write-back, output register.
// Depends on pngu_pkg; reads pngu_row_mem data, fed by pngu_ctrl.
`timescale 1ns / 1ps

module pngu_recon #(
  parameter int MAX_PIXEL_BYTES = 8,
  parameter int AW = 12,
  parameter int KW = 3
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  pngu_pkg::item_t push_item,
  input  logic [AW-1:0]   push_idx,
  input  logic [KW-1:0]   left_sel,
  output logic            s1_free,
  input  logic [7:0]      upper_rd,
  output logic            wr_en,
  output logic [AW-1:0]   wr_addr,
  output logic [7:0]      wr_data,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_pixel_byte,
  output logic            out_row_end,
  output logic            out_bad_filter
);

  import pngu_pkg::*;

  logic          s1_valid_r;
  item_t         s1_item_r;
  logic [AW-1:0] s1_idx_r;
  logic [7:0]    left_r [MAX_PIXEL_BYTES];
  logic [7:0]    ul_r   [MAX_PIXEL_BYTES];
  logic [7:0]    left_eff [MAX_PIXEL_BYTES];
  logic [7:0]    ul_eff   [MAX_PIXEL_BYTES];
  logic          out_valid_r;
  logic [7:0]    pixel_r;
  logic          row_end_r;
  logic          bad_r;

  logic       s1_adv;
  logic       s1_data;
  logic [7:0] a, b, c;
  logic [8:0] ab_sum;
  logic [7:0] pred;
  logic [7:0] x;

  assign s1_adv  = !out_valid_r || out_ready;
  assign s1_free = !s1_valid_r || s1_adv;
  assign s1_data = s1_valid_r && !s1_item_r.bad;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_free) begin
      s1_valid_r <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && push) begin
      s1_item_r <= push_item;
      s1_idx_r  <= push_idx;
    end
  end

  // history restarts at each row
  always_comb begin
    for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
      left_eff[i] = s1_item_r.first ? 8'd0 : left_r[i];
      ul_eff[i]   = s1_item_r.first ? 8'd0 : ul_r[i];
    end
  end

  assign a      = left_eff[left_sel];
  assign c      = ul_eff[left_sel];
  assign b      = s1_item_r.top ? 8'd0 : upper_rd;
  assign ab_sum = {1'b0, a} + {1'b0, b};

  always_comb begin
    unique case (s1_item_r.filt)
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = ab_sum[8:1];
      FILT_PAETH: pred = paeth(a, b, c);
      default:    pred = 8'd0;
    endcase
  end

  assign x = s1_item_r.data + pred;

  assign wr_en   = s1_data && s1_adv;
  assign wr_addr = s1_idx_r;
  assign wr_data = x;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
        left_r[i] <= 8'd0;
        ul_r[i]   <= 8'd0;
      end
    end else if (wr_en) begin
      left_r[0] <= x;
      ul_r[0]   <= b;
      for (int i = 1; i < MAX_PIXEL_BYTES; i++) begin
        left_r[i] <= left_eff[i-1];
        ul_r[i]   <= ul_eff[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      pixel_r   <= s1_item_r.bad ? 8'd0 : x;
      row_end_r <= s1_item_r.last && !s1_item_r.bad;
      bad_r     <= s1_item_r.bad;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_byte = pixel_r;
  assign out_row_end    = row_end_r;
  assign out_bad_filter = bad_r;

endmodule

>>> rtl/core/png_scanline_unfilter.sv
// PNG scanline unfilter.
// Input: one byte per beat on in_* (filter byte, then line_bytes data bytes per row);
// in_new_image marks the first filter byte of an image.
// Output: one reconstructed byte per data beat on out_*, out_row_end on the last
// byte of a row; a filter type above 4 gives one beat with out_bad_filter set,
// after which input is dropped until in_new_image.
// Configuration: cfg_we/cfg_index/cfg_wdata write line_bytes (0) and
// bytes_per_pixel (1); write only while the block is idle.
// Pipeline: an accepted data byte is registered in the reconstruction stage,
// then in the output register, before it is on out_*.
// Throughput: one byte per cycle while out_ready stays high; each data byte costs
// one row-memory read on acceptance and one write as it leaves reconstruction.
// Reset clears control state; the row memory is not cleared, the first row of
// each image reads its upper bytes as zero. When out_ready is low the output
// register holds, the reconstruction stage fills, and in_ready drops.
`timescale 1ns / 1ps

module png_scanline_unfilter #(
  parameter int MAX_LINE_BYTES  = 4096,
  parameter int MAX_PIXEL_BYTES = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [pngu_pkg::LINE_CFG_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_stream_byte,
  input  logic                            in_new_image,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      out_pixel_byte,
  output logic                            out_row_end,
  output logic                            out_bad_filter
);

  import pngu_pkg::*;

  localparam int CW = $clog2(MAX_LINE_BYTES + 1);
  localparam int AW = $clog2(MAX_LINE_BYTES);
  localparam int KW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

  logic          s1_free;
  logic          push;
  item_t         push_item;
  logic          rd_en;
  logic [AW-1:0] rd_idx;
  logic [KW-1:0] left_sel;
  logic [7:0]    upper_rd;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;

  pngu_ctrl #(
    .MAX_LINE_BYTES  (MAX_LINE_BYTES),
    .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES),
    .CW              (CW),
    .AW              (AW),
    .KW              (KW)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_stream_byte (in_stream_byte),
    .in_new_image   (in_new_image),
    .s1_free        (s1_free),
    .push           (push),
    .push_item      (push_item),
    .rd_en          (rd_en),
    .rd_idx         (rd_idx),
    .left_sel       (left_sel)
  );

  pngu_row_mem #(
    .DEPTH (MAX_LINE_BYTES),
    .AW    (AW)
  ) u_row_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_idx),
    .rd_data (upper_rd),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  pngu_recon #(
    .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES),
    .AW              (AW),
    .KW              (KW)
  ) u_recon (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .push_item      (push_item),
    .push_idx       (rd_idx),
    .left_sel       (left_sel),
    .s1_free        (s1_free),
    .upper_rd       (upper_rd),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel_byte (out_pixel_byte),
    .out_row_end    (out_row_end),
    .out_bad_filter (out_bad_filter)
  );

endmodule

>>> tb/png_scanline_unfilter_test.sv
// Self-checking testbench for png_scanline_unfilter: directed rows, a mid-row length change, then random images.
// Keeps its own row reconstruction to predict output beats; directed rows may give the expected beat directly.
// Depends on rtl/core/pngu_pkg.sv and rtl/core/png_scanline_unfilter.sv.
`timescale 1ns / 1ps

module png_scanline_unfilter_test;
  import pngu_pkg::*;

  localparam int ROW_MAX = 4096;
  localparam int PIX_MAX = 8;

  typedef struct packed {
    logic [7:0] pixel;
    logic       row_end;
    logic       bad;
  } beat_t;

  typedef struct {
    logic [7:0] code;
    logic       fresh;
    bit         typed;
    beat_t      want;
  } stim_row_t;

  typedef struct {
    int line;
    int bpp;
    int send_idle;
    int recv_stall;
    int budget;
    int noise;
    int hold;
  } phase_t;

  localparam beat_t NO_BEAT  = '0;
  localparam beat_t BAD_BEAT = '{8'h00, 1'b0, 1'b1};

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic              cfg_index = CFG_LINE_BYTES;
  logic [LINE_CFG_W-1:0] cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [7:0]        in_stream_byte = 8'h00;
  logic              in_new_image = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [7:0]        out_pixel_byte;
  logic              out_row_end;
  logic              out_bad_filter;

  // predictor state
  logic [7:0]   row_mem [ROW_MAX];
  logic [7:0]   left_hist [PIX_MAX] = '{default: 8'h00};
  logic [7:0]   up_hist [PIX_MAX] = '{default: 8'h00};
  int           col = 0;
  filter_t      row_filt = FILT_NONE;
  bit           first_row = 1'b1;
  bit           stopped = 1'b0;
  logic [12:0]  cfg_line = 13'd1;
  logic [3:0]   cfg_bpp = 4'd1;

  beat_t expected_beats [$];
  int    mismatch_count = 0;
  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;
  int    hold_token = 0;
  int    hold_len = 0;

  stim_row_t directed_rows [19] = '{
    '{8'(FILT_NONE),        1'b1, 1'b0, NO_BEAT},
    '{8'h00,                1'b0, 1'b1, '{8'h00, 1'b1, 1'b0}},
    '{8'(FILT_UP),          1'b0, 1'b0, NO_BEAT},
    '{8'hFF,                1'b0, 1'b1, '{8'hFF, 1'b1, 1'b0}},
    '{8'(FILT_SUB),         1'b0, 1'b0, NO_BEAT},
    '{8'h80,                1'b0, 1'b1, '{8'h80, 1'b1, 1'b0}},
    '{8'(FILT_AVG),         1'b0, 1'b0, NO_BEAT},
    '{8'h7F,                1'b0, 1'b0, NO_BEAT},
    '{8'(FILT_PAETH),       1'b0, 1'b0, NO_BEAT},
    '{8'h01,                1'b0, 1'b0, NO_BEAT},
    '{FILT_MAX_CODE + 8'd1, 1'b0, 1'b1, BAD_BEAT},
    '{8'h3C,                1'b0, 1'b0, NO_BEAT},   // dropped while halted
    '{8'(FILT_NONE),        1'b0, 1'b0, NO_BEAT},   // dropped while halted
    '{8'hFF,                1'b1, 1'b1, BAD_BEAT},  // new image, bad filter again
    '{8'hAA,                1'b0, 1'b0, NO_BEAT},
    '{8'(FILT_UP),          1'b1, 1'b0, NO_BEAT},
    '{8'h5A,                1'b0, 1'b1, '{8'h5A, 1'b1, 1'b0}},
    '{8'(FILT_UP),          1'b0, 1'b0, NO_BEAT},
    '{8'h10,                1'b0, 1'b0, NO_BEAT}
  };

  phase_t phases [6] = '{
    '{5,    3,  0,  0,  80, 8, 0},
    '{0,    0,  69, 0,  80, 8, 0},
    '{8,    8,  0,  69, 80, 8, 0},
    '{7,    15, 13, 13, 80, 8, 0},
    '{8191, 4,  0,  0,  80, 0, 0},
    '{3,    2,  0,  0,  80, 8, 300}
  };

  png_scanline_unfilter #(
    .MAX_LINE_BYTES (ROW_MAX),
    .MAX_PIXEL_BYTES(PIX_MAX)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_stream_byte(in_stream_byte),
    .in_new_image  (in_new_image),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pixel_byte(out_pixel_byte),
    .out_row_end   (out_row_end),
    .out_bad_filter(out_bad_filter)
  );

  always #5 clk = ~clk;

  function automatic int eff_line();
    if (cfg_line == 0) return 1;
    if (cfg_line > ROW_MAX) return ROW_MAX;
    return cfg_line;
  endfunction

  // one stream byte through the reconstruction; returns 1 when it yields a beat
  function automatic bit unfilter_step(input logic [7:0] code, input logic fresh,
                                       output beat_t r);
    int idx;
    int k;
    int a;
    int b;
    int c;
    int pred;
    int pa;
    int pb;
    int pc;
    logic [7:0] x;
    bit last;
    r = '0;
    if (fresh) begin
      stopped = 1'b0;
      first_row = 1'b1;
      col = 0;
    end
    if (stopped) return 1'b0;
    if (col == 0) begin
      if (code > FILT_MAX_CODE) begin
        stopped = 1'b1;
        r.bad = 1'b1;
        return 1'b1;
      end
      row_filt = filter_t'(code[2:0]);
      left_hist = '{default: 8'h00};
      up_hist = '{default: 8'h00};
      col = 1;
      return 1'b0;
    end
    idx = (col - 1) % ROW_MAX;
    k = (cfg_bpp == 0) ? 0 : ((cfg_bpp > PIX_MAX) ? PIX_MAX - 1 : cfg_bpp - 1);
    a = left_hist[k];
    b = first_row ? 0 : row_mem[idx];
    c = up_hist[k];
    case (row_filt)
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = (a + b) / 2;
      FILT_PAETH: begin
        pa = (b > c) ? b - c : c - b;
        pb = (a > c) ? a - c : c - a;
        pc = (a + b > 2 * c) ? a + b - 2 * c : 2 * c - a - b;
        if (pa <= pb && pa <= pc) pred = a;
        else if (pb <= pc) pred = b;
        else pred = c;
      end
      default:    pred = 0;
    endcase
    x = 8'(int'(code) + pred);
    row_mem[idx] = x;
    for (int i = PIX_MAX - 1; i > 0; i--) begin
      left_hist[i] = left_hist[i - 1];
      up_hist[i] = up_hist[i - 1];
    end
    left_hist[0] = x;
    up_hist[0] = 8'(b);
    last = (idx + 1) >= eff_line();
    if (last) begin
      col = 0;
      first_row = 1'b0;
    end else begin
      col = col + 1;
    end
    r.pixel = x;
    r.row_end = last;
    return 1'b1;
  endfunction

  // entered and left at a falling edge; holds the beat until it is taken
  task automatic offer_byte(input logic [7:0] code, input logic fresh,
                            input bit typed = 1'b0, input beat_t want = '0);
    beat_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_stream_byte <= code;
    in_new_image <= fresh;
    do @(posedge clk); while (!in_ready);
    if (unfilter_step(code, fresh, r)) expected_beats.push_back(typed ? want : r);
    @(negedge clk);
  endtask

  // pause the sender until every beat is back, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_regs(input logic [12:0] line, input logic [3:0] bpp);
    cfg_we <= 1'b1;
    cfg_index <= CFG_LINE_BYTES;
    cfg_wdata <= line;
    @(negedge clk);
    cfg_index <= CFG_BYTES_PER_PIXEL;
    cfg_wdata <= {9'($urandom), bpp};  // upper bits are don't-care for this register
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_line = line;
    cfg_bpp = bpp;
  endtask

  // random images: mostly whole rows, with bad filters and cut rows as noise
  task automatic run_images(input int budget, input int noise);
    int sent;
    bit need_fresh;
    logic [7:0] code;
    logic fresh;
    sent = 0;
    need_fresh = 1'b1;
    while (sent < budget) begin
      fresh = need_fresh || ($urandom_range(99) < noise);
      need_fresh = 1'b0;
      if ($urandom_range(99) < noise) code = 8'($urandom_range(255, 5));
      else code = 8'($urandom_range(4, 0));
      offer_byte(code, fresh);
      sent++;
      if (code > FILT_MAX_CODE) begin
        repeat ($urandom_range(2)) offer_byte(8'($urandom), 1'b0);
        need_fresh = 1'b1;
        continue;
      end
      for (int i = 0; i < eff_line() && sent < budget; i++) begin
        if ($urandom_range(999) < noise) begin
          need_fresh = 1'b1;  // row cut short, next filter byte restarts the image
          break;
        end
        offer_byte(8'($urandom), 1'b0);
        sent++;
      end
    end
  endtask

  // receiver: random stalls, plus a long hold-off when asked for
  int hold_seen = 0;
  int hold_left = 0;
  always @(negedge clk) begin
    if (hold_seen != hold_token) begin
      hold_seen = hold_token;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    beat_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (expected_beats.size() == 0) begin
        $error("unexpected beat: pixel_byte %0h row_end %0b bad_filter %0b",
               out_pixel_byte, out_row_end, out_bad_filter);
        mismatch_count++;
      end else begin
        want = expected_beats.pop_front();
        if (out_pixel_byte !== want.pixel) begin
          $error("pixel_byte: expected %0h, got %0h", want.pixel, out_pixel_byte);
          mismatch_count++;
        end
        if (out_row_end !== want.row_end) begin
          $error("row_end: expected %0b, got %0b", want.row_end, out_row_end);
          mismatch_count++;
        end
        if (out_bad_filter !== want.bad) begin
          $error("bad_filter: expected %0b, got %0b", want.bad, out_bad_filter);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    int idle_modes [3];
    idle_modes = '{0, 13, 69};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed rows at the reset settings: one byte per row, one byte per pixel
    foreach (directed_rows[i])
      offer_byte(directed_rows[i].code, directed_rows[i].fresh,
                 directed_rows[i].typed, directed_rows[i].want);

    // shrink the row length mid-row: the next data byte must close the row
    settle();
    write_regs(13'd6, 4'd3);
    offer_byte(8'(FILT_PAETH), 1'b1);
    repeat (4) offer_byte(8'($urandom), 1'b0);
    settle();
    write_regs(13'd2, 4'd3);
    offer_byte(8'($urandom), 1'b0);
    offer_byte(8'(FILT_AVG), 1'b0);
    repeat (2) offer_byte(8'($urandom), 1'b0);

    foreach (phases[p]) begin
      settle();
      write_regs(13'(phases[p].line), 4'(phases[p].bpp));
      send_idle_pct = phases[p].send_idle;
      recv_stall_pct = phases[p].recv_stall;
      if (phases[p].hold > 0) begin
        hold_len = phases[p].hold;
        hold_token++;
      end
      run_images(phases[p].budget, phases[p].noise);
    end

    repeat (2) begin
      settle();
      write_regs(13'($urandom_range(12, 1)), 4'($urandom_range(15)));
      send_idle_pct = idle_modes[$urandom_range(2)];
      recv_stall_pct = idle_modes[$urandom_range(2)];
      run_images(60, 8);
    end

    settle();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/pngu_pkg.sv
rtl/core/pngu_row_mem.sv
rtl/core/pngu_ctrl.sv
rtl/core/pngu_recon.sv
rtl/core/png_scanline_unfilter.sv
tb/png_scanline_unfilter_test.sv
